// ===== hw/rtl/gatrp_pkg.sv =====
// Shared types and constants for the glyph atlas tile reorder packer.
// No dependencies; used by the top level.
package gatrp_pkg;

    // Command codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes on the configuration port
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CELL_WIDTH   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CELL_HEIGHT  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INK_VALUE    = 3'd4;

    localparam int CFG_DW  = 9;   // widest register
    localparam int SIZE_W  = 9;   // image dimension width
    localparam int CELL_W  = 8;   // cell dimension width
    localparam int NIB_W   = 4;
    localparam int INK_BITS = 3;  // ink bits that land in a nibble

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [2*SIZE_W-1:0] prod_t;

endpackage

// ===== hw/rtl/gatrp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module gatrp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/glyph_atlas_tile_reorder_pack_unit.sv =====
// Glyph atlas tile reorder packer: raster pixel loads, cell-order 4bpp reads.
// Depends on gatrp_pkg and gatrp_ram (the lit-pixel bit store).
//
// channel  direction  handshake          payload
// -------  ---------  -----------------  ------------------------------------
// command  in         start & !busy      opcode, pixel
// result   out        done (one cycle)   packed_byte, last_byte
// config   in         cfg_we             cfg_addr, cfg_wdata
//
// A load keeps busy high after acceptance for the size multiply and the store
// write. A read keeps busy high for two nibbles, each with one multiply for the
// row offset, one bit-store read and one data state; done pulses in the cycle
// after the last. If no cell fits the image, done pulses in the next cycle.
// One multiplier serves both the image size and the row offset.
// Reset clears positions and restores register defaults; the bit store is
// not cleared. Results cannot be held off by the receiver.
module glyph_atlas_tile_reorder_pack_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           opcode,
    input  logic [7:0]                     pixel,
    output logic                           done,
    output logic [7:0]                     packed_byte,
    output logic                           last_byte,
    input  logic                           cfg_we,
    input  logic [gatrp_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [gatrp_pkg::CFG_DW-1:0]   cfg_wdata
);

    import gatrp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = ((AW > 2 * SIZE_W) ? AW : 2 * SIZE_W) + 1;
    localparam int IDX_W = 2 * SIZE_W + 1;
    localparam size_t W_CAP = SIZE_W'((MAX_WIDTH  > 511) ? 511 : MAX_WIDTH);
    localparam size_t H_CAP = SIZE_W'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LSIZE  = 3'd1;
    localparam logic [2:0] S_LWRITE = 3'd2;
    localparam logic [2:0] S_RMUL   = 3'd3;
    localparam logic [2:0] S_RREAD  = 3'd4;
    localparam logic [2:0] S_RDATA  = 3'd5;

    // configuration
    size_t      img_w_reg, img_h_reg;
    cell_t      cell_w_reg, cell_h_reg, ink_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;
    size_t         ox_reg, ox_next, oy_reg, oy_next;
    cell_t         col_reg, col_next, row_reg, row_next;
    logic          second_reg, second_next;
    logic          wrap_reg, wrap_next;
    logic          done_reg, done_next;

    // payload
    prod_t                  prod_reg;
    logic [SIZE_W:0]        x_reg;
    logic                   inside_reg;
    logic                   lit_reg;
    logic [NIB_W-1:0]       hi_reg;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;

    // derived sizes
    size_t eff_w, eff_h;
    cell_t eff_cw, eff_ch;
    logic  no_fit;

    always_comb
    begin
        eff_w  = (img_w_reg == '0) ? SIZE_W'(1) : ((img_w_reg > W_CAP) ? W_CAP : img_w_reg);
        eff_h  = (img_h_reg == '0) ? SIZE_W'(1) : ((img_h_reg > H_CAP) ? H_CAP : img_h_reg);
        eff_cw = (cell_w_reg == '0) ? CELL_W'(1) : cell_w_reg;
        eff_ch = (cell_h_reg == '0) ? CELL_W'(1) : cell_h_reg;
        no_fit = ({1'b0, eff_cw} > eff_w) || ({1'b0, eff_ch} > eff_h);
    end

    // shared multiplier
    logic [SIZE_W:0] x_cur, y_cur;
    size_t           mul_a;
    prod_t           prod_next;

    assign x_cur = {1'b0, ox_reg} + {2'b0, col_reg};
    assign y_cur = {1'b0, oy_reg} + {2'b0, row_reg};
    assign mul_a = (state_reg == S_LSIZE) ? eff_h : y_cur[SIZE_W-1:0];
    assign prod_next = {{SIZE_W{1'b0}}, mul_a} * {{SIZE_W{1'b0}}, eff_w};

    // store ports
    logic [CMP_W-1:0] pos_ext, size_ext, pos_eff, pos_inc;
    logic [IDX_W-1:0] idx_sum;
    logic             st_we;
    logic [AW-1:0]    st_waddr, st_raddr;
    logic             st_rdata;

    assign size_ext = CMP_W'(prod_reg);
    assign pos_ext  = CMP_W'(pos_reg);
    assign pos_eff  = (pos_ext >= size_ext) ? '0 : pos_ext;
    assign pos_inc  = pos_eff + CMP_W'(1);
    assign st_we    = (state_reg == S_LWRITE);
    assign st_waddr = AW'(pos_eff);
    assign idx_sum  = {1'b0, prod_reg} + IDX_W'(x_reg);
    assign st_raddr = AW'(idx_sum);

    gatrp_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (lit_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // walk to the next pixel in cell order
    logic [CELL_W:0]   col_inc, row_inc;
    logic [SIZE_W:0]   ox_inc, oy_inc;
    logic [SIZE_W+1:0] ox_end, oy_end;
    size_t             ox_adv, oy_adv;
    cell_t             col_adv, row_adv;
    logic              wrap_adv;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 9'd1;
        row_inc  = {1'b0, row_reg} + 9'd1;
        ox_inc   = {1'b0, ox_reg} + {2'b0, eff_cw};
        oy_inc   = {1'b0, oy_reg} + {2'b0, eff_ch};
        ox_end   = {1'b0, ox_inc} + {3'b0, eff_cw};
        oy_end   = {1'b0, oy_inc} + {3'b0, eff_ch};
        col_adv  = col_reg;
        row_adv  = row_reg;
        ox_adv   = ox_reg;
        oy_adv   = oy_reg;
        wrap_adv = 1'b0;
        if (col_inc < {1'b0, eff_cw})
        begin
            col_adv = col_inc[CELL_W-1:0];
        end
        else
        begin
            col_adv = '0;
            if (row_inc < {1'b0, eff_ch})
            begin
                row_adv = row_inc[CELL_W-1:0];
            end
            else
            begin
                row_adv = '0;
                if (ox_end <= {2'b0, eff_w})
                begin
                    ox_adv = ox_inc[SIZE_W-1:0];
                end
                else
                begin
                    ox_adv = '0;
                    if (oy_end <= {2'b0, eff_h})
                    begin
                        oy_adv = oy_inc[SIZE_W-1:0];
                    end
                    else
                    begin
                        oy_adv   = '0;
                        wrap_adv = 1'b1;
                    end
                end
            end
        end
    end

    logic [NIB_W-1:0] nib;
    assign nib = (inside_reg && st_rdata) ? {1'b0, ink_reg[INK_BITS-1:0]} : '0;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        second_next = second_reg;
        wrap_next   = wrap_reg;
        done_next   = 1'b0;
        byte_next   = byte_reg;
        last_next   = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        state_next = S_LSIZE;
                    end
                    else if (no_fit)
                    begin
                        done_next = 1'b1;
                        byte_next = '0;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        second_next = 1'b0;
                        wrap_next   = 1'b0;
                        state_next  = S_RMUL;
                    end
                end
            end
            S_LSIZE:
            begin
                state_next = S_LWRITE;
            end
            S_LWRITE:
            begin
                pos_next   = (pos_inc >= size_ext) ? '0 : AW'(pos_inc);
                state_next = S_IDLE;
            end
            S_RMUL:
            begin
                state_next = S_RREAD;
            end
            S_RREAD:
            begin
                col_next   = col_adv;
                row_next   = row_adv;
                ox_next    = ox_adv;
                oy_next    = oy_adv;
                wrap_next  = wrap_reg | wrap_adv;
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = S_RMUL;
                end
                else
                begin
                    done_next  = 1'b1;
                    byte_next  = {hi_reg, nib};
                    last_next  = wrap_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            second_reg <= 1'b0;
            wrap_reg   <= 1'b0;
            done_reg   <= 1'b0;
            img_w_reg  <= 9'd256;
            img_h_reg  <= 9'd256;
            cell_w_reg <= 8'd16;
            cell_h_reg <= 8'd16;
            ink_reg    <= 8'd1;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            second_reg <= second_next;
            wrap_reg   <= wrap_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:  img_w_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT: img_h_reg  <= cfg_wdata;
                    REG_CELL_WIDTH:   cell_w_reg <= cfg_wdata[CELL_W-1:0];
                    REG_CELL_HEIGHT:  cell_h_reg <= cfg_wdata[CELL_W-1:0];
                    REG_INK_VALUE:    ink_reg    <= cfg_wdata[CELL_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (state_reg == S_IDLE && start && opcode == OP_LOAD)
        begin
            lit_reg <= (pixel != 8'd0);
        end
        if (state_reg == S_LSIZE || state_reg == S_RMUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == S_RMUL)
        begin
            x_reg      <= x_cur;
            inside_reg <= (x_cur < {1'b0, eff_w}) && (y_cur < {1'b0, eff_h});
        end
        if (state_reg == S_RDATA && !second_reg)
        begin
            hi_reg <= nib;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign packed_byte = byte_reg;
    assign last_byte   = last_reg;

endmodule
